// File: rtl/cddf_pkg.sv
// Shared types and constants for the clock digit and dot frame generator.
`default_nettype none

package cddf_pkg;

    // Dot mode codes.
    localparam logic [1:0] DOT_CHASE       = 2'd0;
    localparam logic [1:0] DOT_CLASSIC     = 2'd1;
    localparam logic [1:0] DOT_PROGRESSIVE = 2'd2;
    localparam logic [1:0] DOT_HOLD        = 2'd3;

    // Register indexes, taken from address bit 2.
    localparam logic REG_DOT_STYLE = 1'b0;
    localparam logic REG_FADE_EN   = 1'b1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Dot thresholds: multiples of 32768/7.
    localparam logic [14:0] DOT_THR [6] = '{
        15'd4681, 15'd9362, 15'd14043, 15'd18724, 15'd23405, 15'd28086
    };

    // Fade windows on the prescaler.
    localparam logic [14:0] FADE_LOW  = 15'd4096;
    localparam logic [14:0] FADE_HIGH = 15'd28672;

    // Reciprocals for exact constant division.
    localparam logic [19:0] RECIP_675 = 20'd795365;   // 2^29 / 675, rounded up
    localparam logic [17:0] RECIP_60  = 18'd139811;   // 2^23 / 60, rounded up
    localparam logic [11:0] RECIP_60S = 12'd2185;     // 2^17 / 60, rounded up
    localparam logic [5:0]  RECIP_6   = 6'd43;        // 2^8 / 6, rounded up

    // Residues of 2^10 and 2^20 modulo 675.
    localparam logic [8:0] RES_2P10 = 9'd349;
    localparam logic [8:0] RES_2P20 = 9'd301;

    typedef struct packed {
        logic [31:0] seconds_count;
        logic [14:0] subsecond_ticks;
    } t_frame_in;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [5:0] dot_pattern;
    } t_frame_out;

endpackage

`default_nettype wire

// File: rtl/cddf_stream_if.sv
// Valid/ready stream interface carrying one payload struct per beat.
`default_nettype none

interface cddf_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/clock_digit_and_dot_frame_gen_unit.sv
// Top level of the clock digit and dot frame generator.
// Usage:
//   i_frame carries one display frame per beat: the real-time seconds count and
//   the 15-bit sub-second prescaler. o_digits returns one beat per frame with the
//   HH:MM:SS decimal digits (hours modulo 24) and the six dot enables.
//   The APB port holds two registers: dot_style at 0x0 and fade_enable at 0x4.
//   Write them only while no frame is in flight.
// Throughput:
//   One frame is taken in every cycle unless the pipeline is full and o_digits
//   is not ready. The seven-stage pipeline reduces the displayed seconds modulo
//   86400 and splits them into digits, with one constant-reciprocal multiplier
//   in each stage that needs one.
// Reset:
//   i_rst_n is synchronous and active low. It empties the pipeline, clears the
//   frame phase and the held dot pattern, and sets dot_style to classic and
//   fading off.
// Stalls:
//   Each stage keeps its contents while the stage after it is full and not
//   moving, so a stalled receiver lets i_frame keep filling empty stages until
//   the whole pipeline is full, after which i_frame.ready falls.
`default_nettype none

module clock_digit_and_dot_frame_gen_unit
    import cddf_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    cddf_stream_if.sink            i_frame,
    cddf_stream_if.source          o_digits,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int unsigned NUM_STAGES = 7;

    // Reverse the order of six bits.
    function automatic logic [5:0] mirror6(input logic [5:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 6; i++) begin
            r[5-i] = v[i];
        end
        return r;
    endfunction

    // Tens digit of a value below 60.
    function automatic logic [2:0] tens60(input logic [5:0] v);
        logic [2:0] t;
        priority if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else t = 3'd0;
        return t;
    endfunction

    // Units digit given the value and its tens digit.
    function automatic logic [3:0] units60(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] tx10;
        tx10 = {t, 3'b000} + {2'b00, t, 1'b0};
        return 4'(v - tx10);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] r_dot_style;
    logic       r_fade_en;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_style <= DOT_CLASSIC;
            r_fade_en   <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_DOT_STYLE: r_dot_style <= pwdata[1:0];
                REG_FADE_EN:   r_fade_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DOT_STYLE: prdata = {30'd0, r_dot_style};
            REG_FADE_EN:   prdata = {31'd0, r_fade_en};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when it is empty or
    // when its own contents move on.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   w_take;
    logic                  w_accept;

    always_comb begin
        w_take[NUM_STAGES] = o_digits.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    assign i_frame.ready  = w_take[0];
    assign w_accept       = i_frame.valid && w_take[0];
    assign o_digits.valid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_take[0]) begin
                r_vld[0] <= i_frame.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side: frame phase, fading and the threshold-based dot modes.
    // ------------------------------------------------------------------
    logic [2:0]  r_phase;
    logic [2:0]  n_phase;
    logic [31:0] w_now;
    logic [14:0] w_tpr;
    logic [31:0] w_disp;
    logic [11:0] w_over;
    logic [5:0]  w_gt;
    logic [5:0]  w_lt;
    logic [5:0]  w_ge;
    logic [5:0]  w_dots_in;

    assign w_now   = i_frame.payload.seconds_count;
    assign w_tpr   = i_frame.payload.subsecond_ticks;
    assign n_phase = r_phase + 3'd1;
    assign w_over  = 12'(w_tpr - FADE_HIGH);

    always_comb begin
        w_disp = w_now;
        if (r_fade_en) begin
            if (w_tpr < FADE_LOW) begin
                // Early in the second the previous second shows on some frames.
                if (!(n_phase < {1'b1, w_tpr[11:10]})) begin
                    w_disp = w_now - 32'd1;
                end
            end else if (w_tpr > FADE_HIGH) begin
                // Late in the second the next second shows on some frames.
                if (n_phase < {1'b0, w_over[11:10]}) begin
                    w_disp = w_now + 32'd1;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            w_gt[j] = w_tpr > DOT_THR[j];
            w_lt[j] = w_tpr < DOT_THR[j];
            w_ge[j] = w_tpr >= DOT_THR[j];
        end
        if (r_dot_style == DOT_CHASE) begin
            // The chase direction follows the real seconds, not the faded ones.
            unique case (w_now[1:0])
                2'd0:    w_dots_in = mirror6(w_gt);
                2'd1:    w_dots_in = mirror6(w_lt);
                2'd2:    w_dots_in = w_gt;
                default: w_dots_in = w_lt;
            endcase
        end else begin
            w_dots_in = mirror6(w_ge);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: displayed seconds and pre-computed dots.
    // ------------------------------------------------------------------
    logic [31:0] r_s0_disp;
    logic [5:0]  r_s0_dots;
    logic [1:0]  r_s0_mode;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s0_disp <= w_disp;
            r_s0_dots <= w_dots_in;
            r_s0_mode <= r_dot_style;
        end
    end

    // Stage 1: fold disp/128 into a small value of the same residue mod 675.
    // 86400 = 675 * 128, so disp mod 86400 = (disp/128 mod 675) * 128 + disp[6:0].
    logic [18:0] w_f2;
    logic [18:0] w_f1;
    logic [18:0] w_fold;
    logic [18:0] r_s1_s;
    logic [6:0]  r_s1_b;
    logic [5:0]  r_s1_dots;
    logic [1:0]  r_s1_mode;

    assign w_f2   = 19'({14'd0, r_s0_disp[31:27]} * {10'd0, RES_2P20});
    assign w_f1   = 19'({9'd0, r_s0_disp[26:17]} * {10'd0, RES_2P10});
    assign w_fold = w_f2 + w_f1 + {9'd0, r_s0_disp[16:7]};

    always_ff @(posedge i_clk) begin
        if (w_take[1] && r_vld[0]) begin
            r_s1_s    <= w_fold;
            r_s1_b    <= r_s0_disp[6:0];
            r_s1_dots <= r_s0_dots;
            r_s1_mode <= r_s0_mode;
        end
    end

    // Stage 2: quotient of the folded value by 675.
    logic [38:0] w_p2;
    logic [9:0]  r_s2_q;
    logic [18:0] r_s2_s;
    logic [6:0]  r_s2_b;
    logic [5:0]  r_s2_dots;
    logic [1:0]  r_s2_mode;

    assign w_p2 = {20'd0, r_s1_s} * {19'd0, RECIP_675};

    always_ff @(posedge i_clk) begin
        if (w_take[2] && r_vld[1]) begin
            r_s2_q    <= w_p2[38:29];
            r_s2_s    <= r_s1_s;
            r_s2_b    <= r_s1_b;
            r_s2_dots <= r_s1_dots;
            r_s2_mode <= r_s1_mode;
        end
    end

    // Stage 3: seconds within the day.
    logic [18:0] w_q675;
    logic [9:0]  w_amod;
    logic [16:0] r_s3_r;
    logic [5:0]  r_s3_dots;
    logic [1:0]  r_s3_mode;

    assign w_q675 = 19'({9'd0, r_s2_q} * 19'd675);
    assign w_amod = 10'(r_s2_s - w_q675);

    always_ff @(posedge i_clk) begin
        if (w_take[3] && r_vld[2]) begin
            r_s3_r    <= {w_amod, r_s2_b};
            r_s3_dots <= r_s2_dots;
            r_s3_mode <= r_s2_mode;
        end
    end

    // Stage 4: minutes within the day.
    logic [33:0] w_p4;
    logic [10:0] r_s4_q60;
    logic [16:0] r_s4_r;
    logic [5:0]  r_s4_dots;
    logic [1:0]  r_s4_mode;

    assign w_p4 = {17'd0, r_s3_r} * {16'd0, RECIP_60};

    always_ff @(posedge i_clk) begin
        if (w_take[4] && r_vld[3]) begin
            r_s4_q60  <= w_p4[33:23];
            r_s4_r    <= r_s3_r;
            r_s4_dots <= r_s3_dots;
            r_s4_mode <= r_s3_mode;
        end
    end

    // Stage 5: hours and seconds.
    logic [21:0] w_p5;
    logic [16:0] w_q60x60;
    logic [4:0]  r_s5_h;
    logic [10:0] r_s5_q60;
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_dots;
    logic [1:0]  r_s5_mode;

    assign w_p5     = {11'd0, r_s4_q60} * {10'd0, RECIP_60S};
    assign w_q60x60 = {r_s4_q60, 6'd0} - {4'd0, r_s4_q60, 2'd0};

    always_ff @(posedge i_clk) begin
        if (w_take[5] && r_vld[4]) begin
            r_s5_h    <= w_p5[21:17];
            r_s5_q60  <= r_s4_q60;
            r_s5_sec  <= 6'(r_s4_r - w_q60x60);
            r_s5_dots <= r_s4_dots;
            r_s5_mode <= r_s4_mode;
        end
    end

    // Stage 6: digit split and final dot selection. The held pattern is the
    // dot field of the output register itself.
    logic [10:0] w_h60;
    logic [5:0]  w_min;
    logic [11:0] w_p6;
    logic [3:0]  w_q6;
    logic [2:0]  w_m6;
    logic [1:0]  w_ht;
    logic [2:0]  w_mt;
    logic [2:0]  w_st;
    logic [5:0]  w_dots_out;
    t_frame_out  r_out;

    assign w_h60 = {r_s5_h, 6'd0} - {4'd0, r_s5_h, 2'd0};
    assign w_min = 6'(r_s5_q60 - w_h60);
    // 86400 is a multiple of 6, so disp mod 6 equals seconds mod 6.
    assign w_p6  = {6'd0, r_s5_sec} * {6'd0, RECIP_6};
    assign w_q6  = w_p6[11:8];
    assign w_m6  = 3'(r_s5_sec - {w_q6, 2'b00} - {1'b0, w_q6, 1'b0});
    assign w_mt  = tens60(w_min);
    assign w_st  = tens60(r_s5_sec);

    always_comb begin
        priority if (r_s5_h >= 5'd20) w_ht = 2'd2;
        else if (r_s5_h >= 5'd10) w_ht = 2'd1;
        else w_ht = 2'd0;
    end

    always_comb begin
        unique case (r_s5_mode)
            DOT_CLASSIC: w_dots_out = 6'd1 << w_m6;
            DOT_HOLD:    w_dots_out = r_out.dot_pattern;
            default:     w_dots_out = r_s5_dots;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.dot_pattern <= '0;
        end else if (w_take[6] && r_vld[5]) begin
            r_out.hour_tens    <= w_ht;
            r_out.hour_units   <= units60({1'b0, r_s5_h}, {1'b0, w_ht});
            r_out.minute_tens  <= w_mt;
            r_out.minute_units <= units60(w_min, w_mt);
            r_out.second_tens  <= w_st;
            r_out.second_units <= units60(r_s5_sec, w_st);
            r_out.dot_pattern  <= w_dots_out;
        end
    end

    assign o_digits.payload = r_out;

endmodule

`default_nettype wire

// File: bench/clock_digit_and_dot_frame_gen_unit_tb.sv
// Self-checking testbench for the clock digit and dot frame generator.
`timescale 1ns / 100ps

module clock_digit_and_dot_frame_gen_unit_tb
    import cddf_pkg::*;
();

    // The pipeline is seven stages deep, and that depth sets the extra wait that
    // lets the block settle after the last result beat.
    localparam int unsigned PIPE_LATENCY = 7;
    localparam int unsigned LIMIT_CYCLES = 200000;

    // Prescaler thresholds, derived here rather than taken from the design.
    localparam int unsigned DOT_STEP       = 4681;
    localparam int unsigned FADE_SPAN      = 4096;
    localparam int unsigned FADE_OUT_START = 28672;

    localparam logic [APB_ADDR_W-1:0] ADDR_DOT_STYLE = {REG_DOT_STYLE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_FADE_EN   = {REG_FADE_EN, 2'b00};

    // Dot mode for each random phase. Every mode appears once with fading on
    // and once with fading off, since fading follows the phase parity.
    localparam logic [15:0] PHASE_MODES = {
        DOT_PROGRESSIVE, DOT_HOLD, DOT_CHASE, DOT_CLASSIC,
        DOT_HOLD, DOT_PROGRESSIVE, DOT_CLASSIC, DOT_CHASE
    };
    localparam int unsigned PHASE_COUNT      = 8;
    localparam int unsigned FRAMES_PER_PHASE = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cddf_stream_if #(.t_payload(t_frame_in))  frame_bus ();
    cddf_stream_if #(.t_payload(t_frame_out)) digit_bus ();

    clock_digit_and_dot_frame_gen_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_bus),
        .o_digits (digit_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the block's state and registers, advanced on every accepted
    // frame beat and on every register write.
    logic [2:0]  phase_count;
    logic [5:0]  shown_dots;
    logic [1:0]  cfg_dot_style;
    logic        cfg_fade;

    t_frame_out  pending_frames[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    logic        calm_stretch = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The run is cut off here if it ever hangs, for example when the block
    // swallows a frame and its result never comes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Works out the result beat for one frame and advances the mirrored state.
    // The frame phase steps before it is used, as the block does.
    task automatic render_frame(input t_frame_in beat, output t_frame_out got);
        logic [31:0] now;
        logic [31:0] shown;
        logic [5:0]  dots;
        int unsigned ticks;
        int unsigned thr;
        int unsigned rest;
        int unsigned hours;
        now   = beat.seconds_count;
        ticks = beat.subsecond_ticks;
        shown = now;
        phase_count = phase_count + 1'b1;

        // Near a rollover the shown second is dithered between neighbors:
        // early in the second the old value lingers, late in it the new one
        // shows up ahead of time. Both wrap around the 32-bit count.
        if (cfg_fade) begin
            if (ticks < FADE_SPAN) begin
                if (!(phase_count < 4 + 4 * ticks / FADE_SPAN)) begin
                    shown = now - 1;
                end
            end else if (ticks > FADE_OUT_START) begin
                if (phase_count < 4 * (ticks - FADE_OUT_START) / FADE_SPAN) begin
                    shown = now + 1;
                end
            end
        end

        dots = shown_dots;
        case (cfg_dot_style)
            DOT_CHASE: begin
                // The real second picks the sweep: bit 0 of it selects below
                // versus above the threshold, bit 1 the direction of the tubes.
                dots = '0;
                for (int j = 0; j < 6; j++) begin
                    thr = (j + 1) * DOT_STEP;
                    dots[now[1] ? j : 5 - j] = now[0] ? (ticks < thr) : (ticks > thr);
                end
            end
            DOT_CLASSIC: begin
                dots = 6'd1 << (shown % 6);
            end
            DOT_PROGRESSIVE: begin
                dots = '0;
                for (int j = 0; j < 6; j++) begin
                    dots[5 - j] = ticks >= (j + 1) * DOT_STEP;
                end
            end
            default: begin
                // Hold mode keeps whatever pattern was shown last.
            end
        endcase
        shown_dots = dots;

        rest = shown;
        got.second_units = 4'(rest % 10);
        rest = rest / 10;
        got.second_tens = 3'(rest % 6);
        rest = rest / 6;
        got.minute_units = 4'(rest % 10);
        rest = rest / 10;
        got.minute_tens = 3'(rest % 6);
        rest = rest / 6;
        hours = rest % 24;
        got.hour_units = 4'(hours % 10);
        got.hour_tens = 2'(hours / 10);
        got.dot_pattern = dots;
    endtask

    // Offers one frame beat, with a random gap in front of it unless a calm
    // stretch is running. Valid stays high after the beat so that back-to-back
    // frames go through without a bubble.
    task automatic send_frame(input logic [31:0] secs, input logic [14:0] ticks);
        t_frame_in  beat;
        t_frame_out want;
        beat.seconds_count   = secs;
        beat.subsecond_ticks = ticks;
        @(negedge i_clk);
        while (!calm_stretch && $urandom_range(0, 99) < 35) begin
            frame_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        frame_bus.valid   <= 1'b1;
        frame_bus.payload <= beat;
        do @(posedge i_clk); while (!frame_bus.ready);
        render_frame(beat, want);
        pending_frames.push_back(want);
    endtask

    // Stops offering frames and waits until every result has come back and
    // the pipeline has had time to empty.
    task automatic wait_for_drain();
        @(negedge i_clk);
        frame_bus.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads one register back and compares it with the mirrored value.
    task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != want) begin
            note_error($sformatf("register at 0x%0h: expected 0x%0h, got 0x%0h",
                                 addr, want, got));
        end
    endtask

    // Changes both registers once the block is idle. The upper data bits are
    // filled with noise, which the block has to mask off.
    task automatic program_display(input logic [1:0] mode, input logic fade);
        logic [APB_DATA_W-1:0] noise;
        wait_for_drain();
        noise = $urandom;
        apb_write(ADDR_DOT_STYLE, {noise[APB_DATA_W-1:2], mode});
        noise = $urandom;
        apb_write(ADDR_FADE_EN, {noise[APB_DATA_W-1:1], fade});
        cfg_dot_style = mode;
        cfg_fade      = fade;
        check_register(ADDR_DOT_STYLE, APB_DATA_W'(mode));
        check_register(ADDR_FADE_EN, APB_DATA_W'(fade));
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            note_error($sformatf("%s: expected %0d, got %0d", field, want, got));
        end
    endtask

    // The result side drops ready at random, with an occasional long stall that
    // lets the pipeline fill up and push back.
    always @(negedge i_clk) begin
        if (calm_stretch) begin
            digit_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            digit_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 1) begin
            digit_bus.ready <= 1'b0;
            stall_left <= $urandom_range(8, 20);
        end else begin
            digit_bus.ready <= $urandom_range(0, 99) >= 25;
        end
    end

    // Every result beat is matched against the oldest outstanding frame.
    always @(posedge i_clk) begin : check_results
        t_frame_out want;
        t_frame_out got;
        if (i_rst_n && digit_bus.valid && digit_bus.ready) begin
            got = digit_bus.payload;
            if (pending_frames.size() == 0) begin
                note_error("result beat arrived with no frame outstanding");
            end else begin
                want = pending_frames.pop_front();
                check_field("hour_tens", want.hour_tens, got.hour_tens);
                check_field("hour_units", want.hour_units, got.hour_units);
                check_field("minute_tens", want.minute_tens, got.minute_tens);
                check_field("minute_units", want.minute_units, got.minute_units);
                check_field("second_tens", want.second_tens, got.second_tens);
                check_field("second_units", want.second_units, got.second_units);
                check_field("dot_pattern", want.dot_pattern, got.dot_pattern);
            end
        end
    end

    // Register defaults after reset, then the digit extremes in classic mode:
    // midnight, the last second of a day, the top of the 32-bit count.
    task automatic test_reset_defaults();
        check_register(ADDR_DOT_STYLE, APB_DATA_W'(DOT_CLASSIC));
        check_register(ADDR_FADE_EN, '0);
        send_frame(32'd0, 15'd0);
        send_frame(32'd86399, 15'd32767);
        send_frame(32'hFFFF_FFFF, 15'd4681);
        send_frame(32'd86400, 15'd28086);
        send_frame(32'd43199, 15'h5555);
    endtask

    // All four sweeps of the chase; the first two put the prescaler exactly on a
    // threshold, where neither the above nor the below test holds.
    task automatic test_chase_dots();
        program_display(DOT_CHASE, 1'b0);
        send_frame(32'd0, 15'd4681);
        send_frame(32'd1, 15'd4681);
        send_frame(32'd2, 15'd9363);
        send_frame(32'd3, 15'd9363);
        send_frame(32'd4, 15'd0);
        send_frame(32'd7, 15'd32767);
    endtask

    // Progressive fill just below a threshold and exactly on two of them; then hold mode,
    // which must keep the last fill whatever the frame says.
    task automatic test_progressive_and_hold();
        program_display(DOT_PROGRESSIVE, 1'b0);
        send_frame(32'd100, 15'd4680);
        send_frame(32'd101, 15'd4681);
        send_frame(32'd102, 15'd28086);
        program_display(DOT_HOLD, 1'b0);
        send_frame(32'd103, 15'd0);
        send_frame(32'd104, 15'd32767);
    endtask

    // Both fade windows at their edges, including the wrap from zero down to
    // the top of the count and from the top up to zero.
    task automatic test_fade_window();
        program_display(DOT_CLASSIC, 1'b1);
        send_frame(32'd0, 15'd0);
        send_frame(32'd0, 15'd4095);
        send_frame(32'd1, 15'd4096);
        send_frame(32'd2, 15'd28672);
        send_frame(32'hFFFF_FFFF, 15'd28673);
        send_frame(32'hFFFF_FFFF, 15'd32767);
        send_frame(32'd0, 15'd2048);
        send_frame(32'd0, 15'd2048);
    endtask

    // Random frames over several register settings. A mix of a running clock
    // (which walks the frame phase through the fade windows), day and count
    // boundaries, prescaler values near every threshold, and plain noise.
    task automatic test_random_frames();
        logic [31:0] secs;
        logic [14:0] ticks;
        logic [31:0] run_secs;
        int unsigned run_ticks;
        int unsigned base;
        int unsigned pick;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            program_display(PHASE_MODES[2 * p +: 2], ~p[0]);
            calm_stretch = (p == 3);
            run_secs  = $urandom;
            run_ticks = $urandom_range(0, 32767);
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                secs  = $urandom;
                ticks = 15'($urandom);
                case ($urandom_range(0, 3))
                    0: begin
                        // Plain noise, already drawn above.
                    end
                    1: begin
                        run_ticks = run_ticks + $urandom_range(1, 3000);
                        if (run_ticks > 32767) begin
                            run_ticks = run_ticks - 32768;
                            run_secs  = run_secs + 1;
                        end
                        secs  = run_secs;
                        ticks = 15'(run_ticks);
                    end
                    2: begin
                        pick = $urandom_range(0, 3);
                        if (pick == 0) begin
                            secs = 86400 * $urandom_range(0, 49709) + 86399
                                   + $urandom_range(0, 2);
                        end else if (pick == 1) begin
                            secs = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        end else if (pick == 2) begin
                            secs = $urandom_range(0, 3);
                        end else begin
                            secs = 3600 * $urandom_range(1, 1193046) - 1;
                        end
                    end
                    default: begin
                        pick = $urandom_range(0, 7);
                        if (pick < 6) begin
                            base = (pick + 1) * DOT_STEP;
                        end else if (pick == 6) begin
                            base = FADE_SPAN;
                        end else begin
                            base = FADE_OUT_START;
                        end
                        ticks = 15'(base + $urandom_range(0, 2) - 1);
                    end
                endcase
                send_frame(secs, ticks);
                // Halfway through the second phase the sender waits for every
                // result, so the pipeline runs empty in the middle of a phase.
                if (p == 1 && n == FRAMES_PER_PHASE / 2) begin
                    wait_for_drain();
                end
            end
            calm_stretch = 1'b0;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        frame_bus.valid   = 1'b0;
        frame_bus.payload = '0;
        digit_bus.ready   = 1'b0;
        phase_count       = '0;
        shown_dots        = '0;
        cfg_dot_style     = DOT_CLASSIC;
        cfg_fade          = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_chase_dots();
        test_progressive_and_hold();
        test_fade_window();
        test_random_frames();
        wait_for_drain();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cddf_pkg.sv
rtl/cddf_stream_if.sv
rtl/clock_digit_and_dot_frame_gen_unit.sv
bench/clock_digit_and_dot_frame_gen_unit_tb.sv
